### rtl/ptw_pkg.sv
// Shared constants for the page table walker.
`default_nettype none
package ptw_pkg;

  localparam int VA_BITS_DEF     = 48;
  localparam int TABLE_SLOTS_DEF = 8;
  localparam int OFFSET_BITS     = 12;
  localparam int INDEX_BITS      = 9;
  localparam int ENTRIES         = 1 << INDEX_BITS;
  localparam int FRAME_W         = 40;
  localparam int ENTRY_W         = FRAME_W + 1;
  localparam int VA_W            = 64;
  localparam int SLOT_IN_W       = 3;
  localparam int LEVEL_CNT_W     = 3;

  // recursive view window base: top 24 bits set, bit 39 clear
  localparam logic [23:0] VIEW_BASE_HI = 24'hFF_FFFF;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_WALK  = 1'b1;

endpackage
`default_nettype wire

### rtl/ptw_if.sv
// Valid/ready channel interfaces for walk items and results.
`default_nettype none
interface ptw_in_if;
  logic                             valid;
  logic                             ready;
  logic                             operation;
  logic [ptw_pkg::VA_W-1:0]         virtual_address;
  logic [ptw_pkg::SLOT_IN_W-1:0]    table_slot;
  logic [ptw_pkg::INDEX_BITS-1:0]   entry_index;
  logic                             entry_present;
  logic [ptw_pkg::FRAME_W-1:0]      entry_frame;

  modport source (output valid, operation, virtual_address, table_slot, entry_index,
                  entry_present, entry_frame, input ready);
  modport sink   (input valid, operation, virtual_address, table_slot, entry_index,
                  entry_present, entry_frame, output ready);
endinterface

interface ptw_out_if;
  logic                             valid;
  logic                             ready;
  logic                             is_canonical;
  logic [ptw_pkg::LEVEL_CNT_W-1:0]  levels_found;
  logic [ptw_pkg::FRAME_W-1:0]      directory_pointer_frame;
  logic [ptw_pkg::FRAME_W-1:0]      directory_frame;
  logic [ptw_pkg::FRAME_W-1:0]      leaf_table_frame;
  logic [ptw_pkg::FRAME_W-1:0]      page_frame;
  logic [ptw_pkg::OFFSET_BITS-1:0]  page_offset;
  logic [ptw_pkg::VA_W-1:0]         leaf_table_view_address;
  logic                             table_outside_store;

  modport source (output valid, is_canonical, levels_found, directory_pointer_frame,
                  directory_frame, leaf_table_frame, page_frame, page_offset,
                  leaf_table_view_address, table_outside_store, input ready);
  modport sink   (input valid, is_canonical, levels_found, directory_pointer_frame,
                  directory_frame, leaf_table_frame, page_frame, page_offset,
                  leaf_table_view_address, table_outside_store, output ready);
endinterface
`default_nettype wire

### rtl/page_table_walker.sv
// Top level of the four-level page table walker.
`default_nettype none
// Four-level page table walker with an on-chip table store of TABLE_SLOTS
// tables x 512 entries (present bit + 40-bit frame); a table's slot number is
// its frame number. After reset the store is swept to not-present, one entry
// per cycle, and in_ch.ready stays low until the sweep ends; cfg writes are
// taken at any time. A write word stores one entry and returns an all-zero
// result word in the next cycle. A walk word checks the address for canonical
// form, then reads one entry per level (0 to 4) from the single-read-port
// store: each read returns in the cycle after it is issued and the next level's
// address depends on it, so the levels are read one after another, then the
// result is posted, and the next word is taken once the result register is
// free. A result waiting in the output register holds off the next word until
// it is taken.
module page_table_walker #(
  parameter int VA_BITS     = ptw_pkg::VA_BITS_DEF,
  parameter int TABLE_SLOTS = ptw_pkg::TABLE_SLOTS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  ptw_in_if.sink                             in_ch,
  ptw_out_if.source                          out_ch,
  input  wire logic                          cfg_we,
  input  wire logic [ptw_pkg::SLOT_IN_W-1:0] cfg_wdata
);

  localparam int DEPTH  = TABLE_SLOTS * ptw_pkg::ENTRIES;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int SLOT_W = $clog2(TABLE_SLOTS);
  localparam int HI_W   = ptw_pkg::VA_W - VA_BITS + 1;
  localparam int FW     = ptw_pkg::FRAME_W;
  localparam int IW     = ptw_pkg::INDEX_BITS;
  localparam int LW     = ptw_pkg::LEVEL_CNT_W;

  typedef enum logic [1:0] {ST_CLEAR, ST_IDLE, ST_WALK, ST_RESULT} state_t;

  state_t              state_r, state_nxt;
  logic [ADDR_W-1:0]   clr_r, clr_nxt;
  logic [ptw_pkg::SLOT_IN_W-1:0] root_r, root_nxt;
  logic                out_valid_r, out_valid_nxt;

  // walk context
  logic [ptw_pkg::VA_W-1:0] va_r, va_nxt;
  logic [1:0]          lvl_r, lvl_nxt;       // level of the read in flight
  logic [FW-1:0]       frm_r [4];
  logic [FW-1:0]       frm_nxt [4];
  logic [LW-1:0]       levels_r, levels_nxt;
  logic                outside_r, outside_nxt;
  logic                canon_r, canon_nxt;

  // result register
  logic                o_canon_r, o_canon_nxt;
  logic [LW-1:0]       o_levels_r, o_levels_nxt;
  logic [FW-1:0]       o_frm_r [4];
  logic [FW-1:0]       o_frm_nxt [4];
  logic [ptw_pkg::OFFSET_BITS-1:0] o_off_r, o_off_nxt;
  logic [ptw_pkg::VA_W-1:0] o_view_r, o_view_nxt;
  logic                o_outside_r, o_outside_nxt;

  // store port
  logic                ram_we;
  logic [ADDR_W-1:0]   ram_waddr, ram_raddr;
  logic [ptw_pkg::ENTRY_W-1:0] ram_wdata, ram_rdata;

  logic                in_fire, out_free;
  logic [HI_W-1:0]     va_hi;
  logic                va_canon;
  logic [7:0]          ts8, root8;
  logic [FW-1:0]       rd_frame;
  logic                rd_present;
  logic [IW-1:0]       next_idx;

  ptw_ram #(
    .WIDTH (ptw_pkg::ENTRY_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign out_free     = !out_valid_r || out_ch.ready;
  assign in_ch.ready  = (state_r == ST_IDLE) && out_free;
  assign in_fire      = in_ch.valid && in_ch.ready;

  assign va_hi    = in_ch.virtual_address[ptw_pkg::VA_W-1:VA_BITS-1];
  assign va_canon = (va_hi == '0) || (va_hi == '1);
  assign ts8      = {5'b0, in_ch.table_slot};
  assign root8    = {5'b0, root_r};
  assign rd_frame   = ram_rdata[FW-1:0];
  assign rd_present = ram_rdata[FW];

  // index for the level after the one being returned
  always_comb begin
    case (lvl_r)
      2'd0:    next_idx = va_r[38:30];
      2'd1:    next_idx = va_r[29:21];
      default: next_idx = va_r[20:12];
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    root_nxt      = cfg_we ? cfg_wdata : root_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    va_nxt        = va_r;
    lvl_nxt       = lvl_r;
    frm_nxt       = frm_r;
    levels_nxt    = levels_r;
    outside_nxt   = outside_r;
    canon_nxt     = canon_r;
    o_canon_nxt   = o_canon_r;
    o_levels_nxt  = o_levels_r;
    o_frm_nxt     = o_frm_r;
    o_off_nxt     = o_off_r;
    o_view_nxt    = o_view_r;
    o_outside_nxt = o_outside_r;
    ram_we        = 1'b0;
    ram_waddr     = clr_r;
    ram_wdata     = '0;
    ram_raddr     = '0;

    case (state_r)
      ST_CLEAR: begin
        ram_we  = 1'b1;
        clr_nxt = clr_r + ADDR_W'(1);
        if (clr_r == ADDR_W'(DEPTH - 1)) begin
          state_nxt = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (in_fire) begin
          if (in_ch.operation == ptw_pkg::OP_WRITE) begin
            // slots beyond the store are dropped silently
            ram_we    = ({1'b0, ts8} < 9'(TABLE_SLOTS));
            ram_waddr = {ts8[SLOT_W-1:0], in_ch.entry_index};
            ram_wdata = {in_ch.entry_present, in_ch.entry_frame};
            out_valid_nxt = 1'b1;
            o_canon_nxt   = 1'b0;
            o_levels_nxt  = '0;
            o_frm_nxt     = '{default: '0};
            o_off_nxt     = '0;
            o_view_nxt    = '0;
            o_outside_nxt = 1'b0;
          end else begin
            va_nxt      = in_ch.virtual_address;
            lvl_nxt     = 2'd0;
            frm_nxt     = '{default: '0};
            levels_nxt  = '0;
            outside_nxt = 1'b0;
            canon_nxt   = va_canon;
            ram_raddr   = {root8[SLOT_W-1:0], in_ch.virtual_address[47:39]};
            if (!va_canon) begin
              state_nxt = ST_RESULT;
            end else if ({1'b0, root8} >= 9'(TABLE_SLOTS)) begin
              outside_nxt = 1'b1;
              state_nxt   = ST_RESULT;
            end else begin
              state_nxt = ST_WALK;
            end
          end
        end
      end

      ST_WALK: begin
        ram_raddr = {rd_frame[SLOT_W-1:0], next_idx};
        if (!rd_present) begin
          state_nxt = ST_RESULT;
        end else begin
          frm_nxt[lvl_r] = rd_frame;
          levels_nxt     = levels_r + LW'(1);
          if (lvl_r == 2'd3) begin
            // last level holds a page frame, not a table
            state_nxt = ST_RESULT;
          end else if (rd_frame >= FW'(TABLE_SLOTS)) begin
            outside_nxt = 1'b1;
            state_nxt   = ST_RESULT;
          end else begin
            lvl_nxt = lvl_r + 2'd1;
          end
        end
      end

      ST_RESULT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          o_canon_nxt   = canon_r;
          o_levels_nxt  = levels_r;
          o_frm_nxt     = frm_r;
          o_off_nxt     = va_r[ptw_pkg::OFFSET_BITS-1:0];
          o_view_nxt    = {ptw_pkg::VIEW_BASE_HI, 1'b0, va_r[47:21],
                           {ptw_pkg::OFFSET_BITS{1'b0}}};
          o_outside_nxt = outside_r;
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    va_r        <= va_nxt;
    lvl_r       <= lvl_nxt;
    frm_r       <= frm_nxt;
    levels_r    <= levels_nxt;
    outside_r   <= outside_nxt;
    canon_r     <= canon_nxt;
    o_canon_r   <= o_canon_nxt;
    o_levels_r  <= o_levels_nxt;
    o_frm_r     <= o_frm_nxt;
    o_off_r     <= o_off_nxt;
    o_view_r    <= o_view_nxt;
    o_outside_r <= o_outside_nxt;
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      root_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      root_r      <= root_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_ch.valid                   = out_valid_r;
  assign out_ch.is_canonical            = o_canon_r;
  assign out_ch.levels_found            = o_levels_r;
  assign out_ch.directory_pointer_frame = o_frm_r[0];
  assign out_ch.directory_frame         = o_frm_r[1];
  assign out_ch.leaf_table_frame        = o_frm_r[2];
  assign out_ch.page_frame              = o_frm_r[3];
  assign out_ch.page_offset             = o_off_r;
  assign out_ch.leaf_table_view_address = o_view_r;
  assign out_ch.table_outside_store     = o_outside_r;

endmodule
`default_nettype wire

### rtl/ptw_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module ptw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [WIDTH-1:0]  wdata,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire
